[design/dstq_pkg.sv]
// Shared types and constants for the deadline-sorted task queue.
package dstq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = 5;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_PEEK   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        OP_INSERT = 4'b0001,
        OP_REMOVE = 4'b0010,
        OP_PEEK   = 4'b0100,
        OP_CLEAR  = 4'b1000
    } op_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] task_id;
        logic [31:0] task_deadline;
        logic [7:0]  task_kind;
        logic [31:0] created_at;
    } cmd_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      out_task_id;
        logic [31:0]      out_deadline;
        logic [7:0]       out_kind;
        logic [31:0]      out_created_at;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] task_id;
        logic [7:0]  kind;
        logic [31:0] created_at;
    } slot_t;

    typedef struct packed {
        op_t   op;
        slot_t rec;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } fifo_wr_t;

endpackage

[design/deadline_sorted_task_queue.sv]
// Top level of the deadline-sorted task queue.
// A command transfer happens at a rising edge with start high and busy low;
// cmd carries the action (insert, remove earliest, peek earliest, clear)
// and the task record for an insert. Every command yields exactly one
// result, shown on result for one cycle with done high; it reports status
// (ok, empty, full), the removed or peeked record (zero otherwise) and the
// occupancy after the command. Results come out in command order.
// A command passes in order through the front holding register, the
// command queue and the sorted slot chain, which compares all sixteen
// slots against the new deadline in parallel and shifts them together.
// Throughput is one command per cycle while busy is low, set by that
// parallel chain update; busy rises only if the command queue backs up.
// The receiver cannot stall, so a result is lost if it is not taken in
// its cycle. Reset empties the queue and drops commands in flight; slot
// contents are not cleared, only the fill count.
module deadline_sorted_task_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dstq_pkg::cmd_in_t cmd,
    output logic              done,
    output dstq_pkg::result_t result
);

    dstq_pkg::fifo_wr_t fifo_wr;
    dstq_pkg::cmd_t     fifo_wdata;
    dstq_pkg::cmd_t     fifo_rdata;
    logic               fifo_full;
    logic               fifo_not_empty;
    logic               fifo_pop;

    dstq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .fifo_full (fifo_full),
        .fifo_wr   (fifo_wr),
        .fifo_data (fifo_wdata)
    );

    dstq_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (fifo_wr),
        .wr_data   (fifo_wdata),
        .pop       (fifo_pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .rd_data   (fifo_rdata)
    );

    dstq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (fifo_not_empty),
        .cmd_head  (fifo_rdata),
        .pop       (fifo_pop),
        .done      (done),
        .result    (result)
    );

endmodule

[design/dstq_front.sv]
// Front end: takes command transfers, decodes the action and feeds the command queue.
module dstq_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dstq_pkg::cmd_in_t  cmd,
    input  logic               fifo_full,
    output dstq_pkg::fifo_wr_t fifo_wr,
    output dstq_pkg::cmd_t     fifo_data
);

    logic           valid_reg;
    logic           valid_next;
    dstq_pkg::cmd_t hold_reg;
    dstq_pkg::cmd_t hold_next;
    dstq_pkg::op_t  op_dec;
    logic           forward;
    logic           accept;

    always_comb
    begin
        unique case (cmd.action)
            dstq_pkg::ACT_INSERT: op_dec = dstq_pkg::OP_INSERT;
            dstq_pkg::ACT_REMOVE: op_dec = dstq_pkg::OP_REMOVE;
            dstq_pkg::ACT_PEEK:   op_dec = dstq_pkg::OP_PEEK;
            default:              op_dec = dstq_pkg::OP_CLEAR;
        endcase
    end

    // The holding register frees up in the same cycle its command moves on.
    assign forward = valid_reg && !fifo_full;
    assign busy    = valid_reg && fifo_full;
    assign accept  = start && !busy;

    always_comb
    begin
        valid_next = valid_reg;
        hold_next  = hold_reg;
        if (forward)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next              = 1'b1;
            hold_next.op            = op_dec;
            hold_next.rec.deadline  = cmd.task_deadline;
            hold_next.rec.task_id   = cmd.task_id;
            hold_next.rec.kind      = cmd.task_kind;
            hold_next.rec.created_at = cmd.created_at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign fifo_wr.push = forward;
    assign fifo_wr.full = fifo_full;
    assign fifo_data    = hold_reg;

endmodule

[design/dstq_cmd_fifo.sv]
// Short command queue between the front end and the execution back end.
module dstq_cmd_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  dstq_pkg::fifo_wr_t wr,
    input  dstq_pkg::cmd_t     wr_data,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output dstq_pkg::cmd_t     rd_data
);

    localparam int PTR_W = $clog2(dstq_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(dstq_pkg::FIFO_DEPTH + 1);

    dstq_pkg::cmd_t   mem [dstq_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(dstq_pkg::FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = wr.push && !wr.full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(dstq_pkg::FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(dstq_pkg::FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/dstq_back.sv]
// Back end: sorted slot chain that executes one queued command per cycle.
module dstq_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  dstq_pkg::cmd_t    cmd_head,
    output logic              pop,
    output logic              done,
    output dstq_pkg::result_t result
);

    localparam int DEPTH = dstq_pkg::QUEUE_DEPTH;
    localparam int OCC_W = dstq_pkg::OCC_W;

    dstq_pkg::slot_t   slot_reg [DEPTH];
    dstq_pkg::slot_t   slot_next [DEPTH];
    logic [OCC_W-1:0]  count_reg;
    logic [OCC_W-1:0]  count_next;
    logic              done_reg;
    logic              done_next;
    dstq_pkg::result_t result_reg;
    dstq_pkg::result_t result_next;
    logic [DEPTH-1:0]  place;
    logic              is_full;
    logic              is_empty;

    assign pop      = cmd_valid;
    assign is_full  = count_reg == OCC_W'(DEPTH);
    assign is_empty = count_reg == '0;

    // Every slot compares against the new deadline at once. Slots past the
    // fill level count as later, so the flags rise monotonically along the chain.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            place[i] = (OCC_W'(i) >= count_reg) ||
                       (slot_reg[i].deadline > cmd_head.rec.deadline);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        count_next  = count_reg;
        done_next   = cmd_valid;
        result_next = '0;

        if (cmd_valid)
        begin
            unique case (cmd_head.op)
                dstq_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        result_next.status = dstq_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (i > 0 && place[(i > 0) ? i - 1 : 0])
                            begin
                                slot_next[i] = slot_reg[(i > 0) ? i - 1 : 0];
                            end
                            else if (place[i])
                            begin
                                slot_next[i] = cmd_head.rec;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                dstq_pkg::OP_REMOVE, dstq_pkg::OP_PEEK:
                begin
                    if (is_empty)
                    begin
                        result_next.status = dstq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        result_next.out_task_id    = slot_reg[0].task_id;
                        result_next.out_deadline   = slot_reg[0].deadline;
                        result_next.out_kind       = slot_reg[0].kind;
                        result_next.out_created_at = slot_reg[0].created_at;
                        if (cmd_head.op == dstq_pkg::OP_REMOVE)
                        begin
                            for (int i = 0; i < DEPTH - 1; i++)
                            begin
                                slot_next[i] = slot_reg[i + 1];
                            end
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                dstq_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            result_next.occupancy = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
